>>> design/lvm_pkg.sv
package lvm_pkg;

  localparam int NW       = 52;
  localparam int VW       = 18;
  localparam int CW       = 32;
  localparam int NBITS    = 30;
  localparam int SQ_STEPS = 32;
  localparam int QBITS    = 17;
  localparam int NUMW     = 47;
  localparam int LENW     = 31;
  localparam int NORM_LAT = 57;
  localparam int IN_W     = 288;
  localparam int RES_W    = 258;
  localparam int OUT_W    = 264;

  typedef struct packed {
    logic [2:0][CW-1:0] eye;
    logic [2:0][CW-1:0] hint;
    logic [2:0][VW-1:0] back;
    logic [2:0][VW-1:0] side;
  } lvm_side_t;

endpackage

>>> design/lvm_norm.sv
module lvm_norm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [2:0][lvm_pkg::NW-1:0]    vec_in,
  input  lvm_pkg::lvm_side_t             side_in,
  output logic                           out_valid,
  output logic [2:0][lvm_pkg::VW-1:0]    vec_out,
  output lvm_pkg::lvm_side_t             side_out
);
  import lvm_pkg::*;

  typedef struct packed {
    logic [2:0] sgn;
    logic       zero;
    lvm_side_t  sd;
  } tag_t;

  typedef struct packed {
    logic [63:0]             v;
    logic [63:0]             r;
    logic [2:0][NBITS-1:0]   n;
    tag_t                    tg;
  } sq_t;

  typedef struct packed {
    logic [2:0][NUMW-1:0]  num;
    logic [2:0][QBITS-1:0] q;
    logic [LENW-1:0]       len;
    tag_t                  tg;
  } dv_t;

  logic [NORM_LAT-1:0]     vld;
  logic [2:0][NW-1:0]      a1, a2, a3;
  tag_t                    t1, t2, t3, t4, t5;
  logic [NW-1:0]           m2;
  logic [5:0]              b3;
  logic [5:0]              blen;
  logic [NW-1:0]           mx;
  logic [2:0][NBITS-1:0]   n4, n5;
  logic [2:0][2*NBITS-1:0] p5;
  sq_t                     sq [SQ_STEPS+1];
  dv_t                     dv [QBITS+1];
  logic [2:0][VW-1:0]      ov;
  lvm_side_t               osd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NORM_LAT-2:0], in_valid};
    end
  end

  always_comb begin
    mx = a1[0];
    if (a1[1] > mx) mx = a1[1];
    if (a1[2] > mx) mx = a1[2];
  end

  always_comb begin
    blen = '0;
    for (int j = 0; j < NW; j++) begin
      if (m2[j]) blen = 6'(j + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t1.sgn[i] <= vec_in[i][NW-1];
        a1[i]     <= vec_in[i][NW-1] ? NW'(-vec_in[i]) : vec_in[i];
      end
      t1.zero <= 1'b0;
      t1.sd   <= side_in;
      a2 <= a1;
      m2 <= mx;
      t2 <= t1;
      a3 <= a2;
      b3 <= blen;
      t3 <= {t2.sgn, (m2 == '0), t2.sd};
      for (int i = 0; i < 3; i++) begin
        if (b3 > 6'(NBITS)) begin
          n4[i] <= NBITS'(a3[i] >> (b3 - 6'(NBITS)));
        end else begin
          n4[i] <= NBITS'(a3[i] << (6'(NBITS) - b3));
        end
        p5[i] <= n4[i] * n4[i];
      end
      t4 <= t3;
      n5 <= n4;
      t5 <= t4;
      sq[0].v  <= 64'(p5[0]) + 64'(p5[1]) + 64'(p5[2]);
      sq[0].r  <= '0;
      sq[0].n  <= n5;
      sq[0].tg <= t5;
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    sq_t sq_next;
    always_comb begin
      sq_next = sq[i];
      if (sq[i].v >= sq[i].r + BIT) begin
        sq_next.v = sq[i].v - (sq[i].r + BIT);
        sq_next.r = (sq[i].r >> 1) + BIT;
      end else begin
        sq_next.r = sq[i].r >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq[i+1] <= sq_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv[0].num[i] <= {1'b0, sq[SQ_STEPS].n[i], 16'd0}
                        + NUMW'(sq[SQ_STEPS].r[LENW-1:1]);
      end
      dv[0].q   <= '0;
      dv[0].len <= sq[SQ_STEPS].r[LENW-1:0];
      dv[0].tg  <= sq[SQ_STEPS].tg;
    end
  end

  for (genvar j = 0; j < QBITS; j++) begin : g_div
    localparam int K = QBITS - 1 - j;
    dv_t dv_next;
    always_comb begin
      dv_next = dv[j];
      for (int i = 0; i < 3; i++) begin
        if (dv[j].num[i] >= (NUMW'(dv[j].len) << K)) begin
          dv_next.num[i]  = dv[j].num[i] - (NUMW'(dv[j].len) << K);
          dv_next.q[i][K] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1] <= dv_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv[QBITS].tg.zero) begin
          ov[i] <= '0;
        end else if (dv[QBITS].tg.sgn[i]) begin
          ov[i] <= VW'(-{1'b0, dv[QBITS].q[i]});
        end else begin
          ov[i] <= {1'b0, dv[QBITS].q[i]};
        end
      end
      osd <= dv[QBITS].tg.sd;
    end
  end

  assign out_valid = vld[NORM_LAT-1];
  assign vec_out   = ov;
  assign side_out  = osd;

endmodule

>>> design/lookat_view_matrix_unit.sv
// Channel   Direction  Word
// s_*       in         eye, target and up hint vectors, one set per word
// m_*       out        side, up and back axes and the translation
//
// A word is taken every cycle unless a full skid register holds s_tready low.
// Each word passes through the three normalising units, each 57 stages deep,
// with their 32-step square root and 17-step division pipelines.
// Reset clears all valid bits and the output and skid flags.
// A stall on the output fills the skid register and then freezes the pipe.
module lookat_view_matrix_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, hint_x, hint_y, hint_z
  input  logic [lvm_pkg::IN_W-1:0]      s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // side_x, side_y, side_z, upvec_x, upvec_y, upvec_z, back_x, back_y,
  // back_z, trans_x, trans_y, trans_z, zero padding
  output logic [lvm_pkg::OUT_W-1:0]     m_tdata
);
  import lvm_pkg::*;

  logic                       en;
  logic                       v0, vc1a, vc1b, vc2a, vc2b, vta, vtb;
  logic                       n1v, n2v, n3v;
  logic [2:0][32:0]           d0;
  lvm_side_t                  sd0, sdc1a, sdc1b, sdc2a, sdc2b;
  logic [2:0][NW-1:0]         nin1, nin2, nin3;
  logic [2:0][VW-1:0]         n1o, n2o, n3o;
  lvm_side_t                  n1s, n2s, n3s;
  logic signed [49:0]         p1 [6];
  logic signed [35:0]         p2 [6];
  logic signed [50:0]         c1 [3];
  logic signed [36:0]         c2 [3];
  logic signed [49:0]         pt [3][3];
  logic signed [52:0]         st [3];
  logic [2:0][2:0][VW-1:0]    axa, axb;
  logic [2:0][CW-1:0]         trans;
  logic signed [36:0]         qt [3];
  logic [RES_W-1:0]           res, odata, skid;
  logic                       ovalid, skid_full, take;

  assign en       = !skid_full;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; vc1a <= 1'b0; vc1b <= 1'b0; vc2a <= 1'b0;
      vc2b <= 1'b0; vta <= 1'b0; vtb <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid; vc1a <= n1v; vc1b <= vc1a; vc2a <= n2v;
      vc2b <= vc2a; vta <= n3v; vtb <= vta;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d0[i] <= {s_tdata[CW*i+CW-1], s_tdata[CW*i +: CW]}
               - {s_tdata[CW*(i+3)+CW-1], s_tdata[CW*(i+3) +: CW]};
        sd0.eye[i]  <= s_tdata[CW*i +: CW];
        sd0.hint[i] <= s_tdata[CW*(i+6) +: CW];
      end
      sd0.back <= '0;
      sd0.side <= '0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nin1[i] = {{(NW-33){d0[i][32]}}, d0[i]};
      nin2[i] = {{(NW-51){c1[i][50]}}, c1[i]};
      nin3[i] = {{(NW-37){c2[i][36]}}, c2[i]};
    end
  end

  lvm_norm u_norm_back (
    .clk(clk), .rst(rst), .en(en), .in_valid(v0), .vec_in(nin1), .side_in(sd0),
    .out_valid(n1v), .vec_out(n1o), .side_out(n1s)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      p1[0] <= $signed(n1s.hint[1]) * $signed(n1o[2]);
      p1[1] <= $signed(n1s.hint[2]) * $signed(n1o[1]);
      p1[2] <= $signed(n1s.hint[2]) * $signed(n1o[0]);
      p1[3] <= $signed(n1s.hint[0]) * $signed(n1o[2]);
      p1[4] <= $signed(n1s.hint[0]) * $signed(n1o[1]);
      p1[5] <= $signed(n1s.hint[1]) * $signed(n1o[0]);
      sdc1a <= {n1s.eye, n1s.hint, n1o, n1s.side};
      for (int i = 0; i < 3; i++) begin
        c1[i] <= 51'(p1[2*i]) - 51'(p1[2*i+1]);
      end
      sdc1b <= sdc1a;
    end
  end

  lvm_norm u_norm_side (
    .clk(clk), .rst(rst), .en(en), .in_valid(vc1b), .vec_in(nin2),
    .side_in(sdc1b), .out_valid(n2v), .vec_out(n2o), .side_out(n2s)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      p2[0] <= $signed(n2s.back[1]) * $signed(n2o[2]);
      p2[1] <= $signed(n2s.back[2]) * $signed(n2o[1]);
      p2[2] <= $signed(n2s.back[2]) * $signed(n2o[0]);
      p2[3] <= $signed(n2s.back[0]) * $signed(n2o[2]);
      p2[4] <= $signed(n2s.back[0]) * $signed(n2o[1]);
      p2[5] <= $signed(n2s.back[1]) * $signed(n2o[0]);
      sdc2a <= {n2s.eye, n2s.hint, n2s.back, n2o};
      for (int i = 0; i < 3; i++) begin
        c2[i] <= 37'(p2[2*i]) - 37'(p2[2*i+1]);
      end
      sdc2b <= sdc2a;
    end
  end

  lvm_norm u_norm_up (
    .clk(clk), .rst(rst), .en(en), .in_valid(vc2b), .vec_in(nin3),
    .side_in(sdc2b), .out_valid(n3v), .vec_out(n3o), .side_out(n3s)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      axa[0] <= n3s.side;
      axa[1] <= n3o;
      axa[2] <= n3s.back;
      for (int i = 0; i < 3; i++) begin
        pt[0][i] <= $signed(n3s.side[i]) * $signed(n3s.eye[i]);
        pt[1][i] <= $signed(n3o[i]) * $signed(n3s.eye[i]);
        pt[2][i] <= $signed(n3s.back[i]) * $signed(n3s.eye[i]);
      end
      axb <= axa;
      for (int k = 0; k < 3; k++) begin
        st[k] <= 53'sd32768 - (53'(pt[k][0]) + 53'(pt[k][1]) + 53'(pt[k][2]));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qt[k] = 37'(st[k] >>> 16);
      if (qt[k][36:31] == '0 || qt[k][36:31] == '1) begin
        trans[k] = qt[k][31:0];
      end else if (qt[k][36]) begin
        trans[k] = 32'h8000_0000;
      end else begin
        trans[k] = 32'h7fff_ffff;
      end
    end
    res = {trans[2], trans[1], trans[0],
           axb[2][2], axb[2][1], axb[2][0],
           axb[1][2], axb[1][1], axb[1][0],
           axb[0][2], axb[0][1], axb[0][0]};
  end

  assign take = !ovalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid    <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (m_tready) skid_full <= 1'b0;
    end else if (vtb) begin
      if (take) ovalid <= 1'b1;
      else      skid_full <= 1'b1;
    end else if (m_tready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (m_tready) odata <= skid;
    end else if (vtb) begin
      if (take) odata <= res;
      else      skid  <= res;
    end
  end

  assign m_tvalid = ovalid;
  assign m_tdata  = {(OUT_W - RES_W)'(0), odata};

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> m_tvalid) else $error("skid word held without output word");

  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && vtb && !skid_full) |=> skid_full)
    else $error("stalled result word was not captured");

  a_back_unit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[125:108]) <= 18'sd65536 &&
                  $signed(m_tdata[125:108]) >= -18'sd65536))
    else $error("back axis component out of range");

endmodule
